@@ rtl/core/rab_pkg.sv @@
package rab_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int PIX_W          = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR  = 3'd0,
    REG_BLEND_ALPHA = 3'd1,
    REG_PIXEL_MODE  = 3'd2,
    REG_RECT_LEFT   = 3'd3,
    REG_RECT_TOP    = 3'd4,
    REG_RECT_WIDTH  = 3'd5,
    REG_RECT_HEIGHT = 3'd6
  } reg_idx_t;

  localparam logic [1:0] MODE_ARGB8888 = 2'd0;
  localparam logic [1:0] MODE_RGB565   = 2'd1;

  localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

  // register file contents
  typedef struct packed {
    logic [23:0]        fill_color;
    logic [7:0]         blend_alpha;
    logic [1:0]         pixel_mode;
    logic signed [12:0] rect_left;
    logic signed [12:0] rect_top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
  } cfg_t;

  // after coordinate test and channel unpack
  typedef struct packed {
    logic             blend;
    logic             is565;
    logic [7:0]       dst_r;
    logic [7:0]       dst_g;
    logic [7:0]       dst_b;
    logic [PIX_W-1:0] dest;
  } stage_a_t;

endpackage

@@ rtl/core/rect_alpha_blend_pixel_unit.sv @@
// Constant-alpha rectangle blend for a framebuffer pixel stream. Each request
// carries a pixel's column, row and raw framebuffer word; when the pixel lies
// inside the programmed rectangle (left/top signed, width/height in pixels)
// and the mode is ARGB8888 or RGB565, each colour channel is replaced by
// (fill*alpha + dest*(255-alpha))/255 truncated, with alpha forced to 0xFF in
// ARGB8888 and the upper half cleared in RGB565; otherwise the word passes
// through untouched and out_tuser is low. The block accepts one pixel per
// clock unless out_tready stalls it, through three register stages:
// coordinate test and unpack, channel multiply-accumulate, then
// divide-by-255 and repack into the output register. Backpressure on
// out_tready stalls only the stages that are full, so bubbles are squeezed
// out. Program the registers only while no pixel is in flight.
module rect_alpha_blend_pixel_unit
  import rab_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_BITS   = 2*COORD_BITS + PIX_W,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // pixel requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // pixel_col, pixel_row, dest_pixel
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // result_pixel
  output logic                  out_tuser   // was_blended
);

  // register file
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fill_color  <= '0;
      cfg_r.blend_alpha <= ALPHA_OPAQUE;
      cfg_r.pixel_mode  <= MODE_ARGB8888;
      cfg_r.rect_left   <= '0;
      cfg_r.rect_top    <= '0;
      cfg_r.rect_width  <= '0;
      cfg_r.rect_height <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FILL_COLOR:  cfg_r.fill_color  <= cfg_wdata[23:0];
        REG_BLEND_ALPHA: cfg_r.blend_alpha <= cfg_wdata[7:0];
        REG_PIXEL_MODE:  cfg_r.pixel_mode  <= cfg_wdata[1:0];
        REG_RECT_LEFT:   cfg_r.rect_left   <= $signed(cfg_wdata[12:0]);
        REG_RECT_TOP:    cfg_r.rect_top    <= $signed(cfg_wdata[12:0]);
        REG_RECT_WIDTH:  cfg_r.rect_width  <= cfg_wdata[11:0];
        REG_RECT_HEIGHT: cfg_r.rect_height <= cfg_wdata[11:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when it drains
  logic v_a_r, v_b_r, v_c_r;
  logic v_a_nxt, v_b_nxt, v_c_nxt;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c     = !v_c_r || out_tready;
  assign rdy_b     = !v_b_r || rdy_c;
  assign rdy_a     = !v_a_r || rdy_b;
  assign in_tready = rdy_a;

  assign v_a_nxt = rdy_a ? in_tvalid : v_a_r;
  assign v_b_nxt = rdy_b ? v_a_r : v_b_r;
  assign v_c_nxt = rdy_c ? v_b_r : v_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
    end
  end

  // stage a: rectangle test and channel unpack
  stage_a_t stage_a;

  rab_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk        (clk),
    .en         (rdy_a),
    .pixel_col  (in_tdata[COORD_BITS-1:0]),
    .pixel_row  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .dest_pixel (in_tdata[2*COORD_BITS+PIX_W-1:2*COORD_BITS]),
    .cfg        (cfg_r),
    .stage_a    (stage_a)
  );

  // stage b: per-channel multiply-accumulate, control rides alongside
  logic [7:0]       mix_r, mix_g, mix_b;
  logic             blend_b_r, is565_b_r;
  logic [PIX_W-1:0] dest_b_r;

  rab_mix_channel u_mix_r (
    .clk   (clk),
    .en    (rdy_b),
    .src   (cfg_r.fill_color[23:16]),
    .dst   (stage_a.dst_r),
    .alpha (cfg_r.blend_alpha),
    .mixed (mix_r)
  );

  rab_mix_channel u_mix_g (
    .clk   (clk),
    .en    (rdy_b),
    .src   (cfg_r.fill_color[15:8]),
    .dst   (stage_a.dst_g),
    .alpha (cfg_r.blend_alpha),
    .mixed (mix_g)
  );

  rab_mix_channel u_mix_b (
    .clk   (clk),
    .en    (rdy_b),
    .src   (cfg_r.fill_color[7:0]),
    .dst   (stage_a.dst_b),
    .alpha (cfg_r.blend_alpha),
    .mixed (mix_b)
  );

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      blend_b_r <= stage_a.blend;
      is565_b_r <= stage_a.is565;
      dest_b_r  <= stage_a.dest;
    end
  end

  // stage c: repack into the output register
  logic [PIX_W-1:0] res_nxt, res_r;
  logic             blended_r;

  always_comb begin
    if (!blend_b_r) begin
      res_nxt = dest_b_r;                    // pass through untouched
    end else if (is565_b_r) begin
      res_nxt = {16'h0000, mix_r[7:3], mix_g[7:2], mix_b[7:3]};
    end else begin
      res_nxt = {ALPHA_OPAQUE, mix_r, mix_g, mix_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      res_r     <= res_nxt;
      blended_r <= blend_b_r;
    end
  end

  assign out_tvalid = v_c_r;
  assign out_tdata  = res_r;
  assign out_tuser  = blended_r;

endmodule

@@ rtl/core/rab_decode.sv @@
module rab_decode
  import rab_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [PIX_W-1:0]      dest_pixel,
  input  cfg_t                  cfg,
  output stage_a_t              stage_a
);

  // signed compare width covering coordinate, edge and edge plus size
  localparam int CW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;

  logic signed [CW-1:0] col_s, row_s, left_s, top_s, right_s, bottom_s;
  logic                 in_rect;
  stage_a_t             stage_a_nxt, stage_a_r;

  assign col_s    = $signed({{(CW-COORD_BITS){1'b0}}, pixel_col});
  assign row_s    = $signed({{(CW-COORD_BITS){1'b0}}, pixel_row});
  assign left_s   = $signed({{(CW-13){cfg.rect_left[12]}}, cfg.rect_left});
  assign top_s    = $signed({{(CW-13){cfg.rect_top[12]}}, cfg.rect_top});
  assign right_s  = left_s + $signed({{(CW-12){1'b0}}, cfg.rect_width});
  assign bottom_s = top_s + $signed({{(CW-12){1'b0}}, cfg.rect_height});

  assign in_rect = (col_s >= left_s) && (col_s < right_s) &&
                   (row_s >= top_s) && (row_s < bottom_s);

  always_comb begin
    stage_a_nxt.dest  = dest_pixel;
    stage_a_nxt.is565 = (cfg.pixel_mode == MODE_RGB565);
    stage_a_nxt.blend = in_rect && ((cfg.pixel_mode == MODE_ARGB8888) ||
                                    (cfg.pixel_mode == MODE_RGB565));
    if (cfg.pixel_mode == MODE_RGB565) begin
      // expand by shift, no bit replication
      stage_a_nxt.dst_r = {dest_pixel[15:11], 3'b000};
      stage_a_nxt.dst_g = {dest_pixel[10:5], 2'b00};
      stage_a_nxt.dst_b = {dest_pixel[4:0], 3'b000};
    end else begin
      stage_a_nxt.dst_r = dest_pixel[23:16];
      stage_a_nxt.dst_g = dest_pixel[15:8];
      stage_a_nxt.dst_b = dest_pixel[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_a_r <= stage_a_nxt;
    end
  end

  assign stage_a = stage_a_r;

endmodule

@@ rtl/core/rab_mix_channel.sv @@
module rab_mix_channel
  import rab_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] src,
  input  logic [7:0] dst,
  input  logic [7:0] alpha,
  output logic [7:0] mixed
);

  logic [15:0] sum_nxt, sum_r;
  logic [16:0] div_tmp;

  assign sum_nxt = (src * alpha) + (dst * (ALPHA_OPAQUE - alpha));

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // exact floor(x/255) for x up to 255*255
  assign div_tmp = {1'b0, sum_r} + 17'd1 + {9'd0, sum_r[15:8]};
  assign mixed   = div_tmp[15:8];

endmodule

@@ rtl/core/rab_checker.sv @@
module rab_checker
  import rab_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata,
  input logic             out_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // a blended pixel is either opaque argb or a clean rgb565 word
  a_blend_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[31:24] == ALPHA_OPAQUE) || (out_tdata[31:16] == 16'h0000))
    else $error("blended pixel has bad upper bits");

endmodule

bind rect_alpha_blend_pixel_unit rab_checker u_rab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
